FILE: rtl/core/pcm_saturate_and_stats_defines.svh
// Assertion macros shared by the PCM saturation block.
// Included by the top level only; needs no package.
`ifndef PCM_SATURATE_AND_STATS_DEFINES_SVH
`define PCM_SATURATE_AND_STATS_DEFINES_SVH

// Condition b must hold in the same cycle as a.
`define PCM_ASSERT_SAME(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Condition b must hold in the cycle after a.
`define PCM_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

FILE: rtl/core/pcm_sat_pkg.sv
// Types and constants of the PCM saturation and statistics block.
// Used by the interfaces and by every module of the block.
package pcm_sat_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int PCM_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int SQUARE_W   = 31;
    localparam int COUNT_W    = 25;
    localparam int ENERGY_W   = 55;
    localparam int CHAN_CFG_W = 5;
    localparam int POS_W      = 4;

    // Saturation limits of the 16-bit result.
    localparam logic [PCM_W-1:0] PCM_POS_LIMIT = 16'h7FFF;
    localparam logic [PCM_W-1:0] PCM_NEG_LIMIT = 16'h8000;

    // Saturation points of the block counters and energy sums.
    localparam logic [COUNT_W-1:0]  MAX_BLOCK_SAMPLES = 25'd16777216;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = ENERGY_W'(64'h0040_0000_0000_0000);

    // Channel count register.
    localparam logic [CHAN_CFG_W-1:0] CHAN_RESET = 5'd2;
    localparam logic [CHAN_CFG_W-1:0] CHAN_LIMIT = 5'd16;

    // Channel positions that feed the energy sums.
    localparam logic [POS_W-1:0] POS_LEFT  = 4'd0;
    localparam logic [POS_W-1:0] POS_RIGHT = 4'd1;

    // Word handed from the saturation stage to the statistics stage.
    typedef struct packed {
        logic [PCM_W-1:0]    pcm;
        logic                clipped;
        logic                nonzero;
        logic [SAMPLE_W-1:0] magnitude;
        logic [SQUARE_W-1:0] square;
        logic                block_start;
    } pcm_sat_word_t;

endpackage

FILE: rtl/core/pcm_sat_if.sv
// Stream interfaces of the PCM saturation block: samples, results, configuration.
// Depends on pcm_sat_pkg for the field widths.
interface pcm_sat_in_if import pcm_sat_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_start;

    modport source (output valid, output sample, output block_start, input ready);
    modport sink (input valid, input sample, input block_start, output ready);
endinterface

interface pcm_sat_out_if import pcm_sat_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   low_byte;
    logic [BYTE_W-1:0]   high_byte;
    logic                clipped;
    logic [SAMPLE_W-1:0] peak_magnitude;
    logic [COUNT_W-1:0]  clip_total;
    logic [COUNT_W-1:0]  nonzero_total;
    logic [ENERGY_W-1:0] left_energy;
    logic [ENERGY_W-1:0] right_energy;

    modport source (output valid, output low_byte, output high_byte, output clipped,
                    output peak_magnitude, output clip_total, output nonzero_total,
                    output left_energy, output right_energy, input ready);
    modport sink (input valid, input low_byte, input high_byte, input clipped,
                  input peak_magnitude, input clip_total, input nonzero_total,
                  input left_energy, input right_energy, output ready);
endinterface

interface pcm_sat_cfg_if import pcm_sat_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CHAN_CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/pcm_sat_front.sv
// Saturation stage: clamps a 32-bit sample to 16 bits, takes its magnitude
// and square, and registers the word. Depends on pcm_sat_pkg.
module pcm_sat_front import pcm_sat_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       block_start,
    output logic                       word_valid,
    input  logic                       word_ready,
    output pcm_sat_word_t              word
);

    logic                       valid_reg;
    pcm_sat_word_t              word_reg;
    pcm_sat_word_t              word_next;
    logic                       neg;
    logic                       clip_pos;
    logic                       clip_neg;
    logic [PCM_W-1:0]           pcm;
    logic signed [2*PCM_W-1:0]  square_full;

    // The stage takes a word whenever it is empty or its word moves on.
    assign in_ready   = !valid_reg || word_ready;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    // A positive sample clips when any of bits 30..15 is set; a negative one
    // clips unless bits 30..15 are all ones.
    assign neg      = sample[SAMPLE_W-1];
    assign clip_pos = !neg && (|sample[SAMPLE_W-2:PCM_W-1]);
    assign clip_neg = neg && !(&sample[SAMPLE_W-2:PCM_W-1]);

    always_comb
    begin
        if (clip_pos)
        begin
            pcm = PCM_POS_LIMIT;
        end
        else if (clip_neg)
        begin
            pcm = PCM_NEG_LIMIT;
        end
        else
        begin
            pcm = sample[PCM_W-1:0];
        end
    end

    // The square of the signed 16-bit result never exceeds 2^30.
    assign square_full = $signed(pcm) * $signed(pcm);

    always_comb
    begin
        word_next.pcm         = pcm;
        word_next.clipped     = clip_pos || clip_neg;
        word_next.nonzero     = |pcm;
        word_next.magnitude   = neg ? (~sample + SAMPLE_W'(1)) : sample;
        word_next.square      = square_full[SQUARE_W-1:0];
        word_next.block_start = block_start;
    end

    // Occupancy of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

FILE: rtl/core/pcm_sat_stats.sv
// Statistics stage: updates the block statistics with one word and holds the
// result until it is taken. Also holds the channel count. Depends on pcm_sat_pkg.
module pcm_sat_stats import pcm_sat_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  word_valid,
    output logic                  word_ready,
    input  pcm_sat_word_t         word,
    input  logic                  cfg_valid,
    input  logic [CHAN_CFG_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BYTE_W-1:0]     low_byte,
    output logic [BYTE_W-1:0]     high_byte,
    output logic                  clipped,
    output logic [SAMPLE_W-1:0]   peak_magnitude,
    output logic [COUNT_W-1:0]    clip_total,
    output logic [COUNT_W-1:0]    nonzero_total,
    output logic [ENERGY_W-1:0]   left_energy,
    output logic [ENERGY_W-1:0]   right_energy
);

    logic                  out_valid_reg;
    logic [CHAN_CFG_W-1:0] chan_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [SAMPLE_W-1:0]   peak_reg;
    logic [SAMPLE_W-1:0]   peak_next;
    logic [COUNT_W-1:0]    clip_reg;
    logic [COUNT_W-1:0]    clip_next;
    logic [COUNT_W-1:0]    nonzero_reg;
    logic [COUNT_W-1:0]    nonzero_next;
    logic [ENERGY_W-1:0]   left_reg;
    logic [ENERGY_W-1:0]   left_next;
    logic [ENERGY_W-1:0]   right_reg;
    logic [ENERGY_W-1:0]   right_next;
    logic [PCM_W-1:0]      pcm_reg;
    logic                  clipped_reg;

    logic                  take;
    logic [POS_W-1:0]      pos_base;
    logic [SAMPLE_W-1:0]   peak_base;
    logic [COUNT_W-1:0]    clip_base;
    logic [COUNT_W-1:0]    nonzero_base;
    logic [ENERGY_W-1:0]   left_base;
    logic [ENERGY_W-1:0]   right_base;
    logic [CHAN_CFG_W-1:0] chan_eff;
    logic [CHAN_CFG_W-1:0] pos_inc;
    logic [ENERGY_W:0]     energy_sum;
    logic [ENERGY_W-1:0]   energy_sat;

    // The result register frees up when empty or taken.
    assign word_ready = !out_valid_reg || out_ready;
    assign take       = word_valid && word_ready;

    // A block start clears the statistics before this word counts.
    always_comb
    begin
        if (word.block_start)
        begin
            pos_base     = '0;
            peak_base    = '0;
            clip_base    = '0;
            nonzero_base = '0;
            left_base    = '0;
            right_base   = '0;
        end
        else
        begin
            pos_base     = pos_reg;
            peak_base    = peak_reg;
            clip_base    = clip_reg;
            nonzero_base = nonzero_reg;
            left_base    = left_reg;
            right_base   = right_reg;
        end
    end

    // Zero channels run as one, more than sixteen as sixteen.
    always_comb
    begin
        if (chan_reg == '0)
        begin
            chan_eff = CHAN_CFG_W'(1);
        end
        else if (chan_reg > CHAN_LIMIT)
        begin
            chan_eff = CHAN_LIMIT;
        end
        else
        begin
            chan_eff = chan_reg;
        end
    end

    // Channel position wraps at the frame end.
    assign pos_inc  = {1'b0, pos_base} + CHAN_CFG_W'(1);
    assign pos_next = (pos_inc >= chan_eff) ? '0 : pos_inc[POS_W-1:0];

    // Peak and the saturating sample counters.
    always_comb
    begin
        peak_next = (word.magnitude > peak_base) ? word.magnitude : peak_base;

        clip_next = clip_base;
        if (word.clipped)
        begin
            clip_next = (clip_base >= MAX_BLOCK_SAMPLES) ? MAX_BLOCK_SAMPLES
                                                          : clip_base + COUNT_W'(1);
        end

        nonzero_next = nonzero_base;
        if (word.nonzero)
        begin
            nonzero_next = (nonzero_base >= MAX_BLOCK_SAMPLES) ? MAX_BLOCK_SAMPLES
                                                                : nonzero_base + COUNT_W'(1);
        end
    end

    // The square goes into whichever energy sum this channel feeds.
    always_comb
    begin
        case (pos_base)
            POS_LEFT:  energy_sum = {1'b0, left_base} + (ENERGY_W + 1)'(word.square);
            POS_RIGHT: energy_sum = {1'b0, right_base} + (ENERGY_W + 1)'(word.square);
            default:   energy_sum = '0;
        endcase
        energy_sat = (energy_sum > {1'b0, ENERGY_MAX}) ? ENERGY_MAX
                                                       : energy_sum[ENERGY_W-1:0];
        left_next  = (pos_base == POS_LEFT) ? energy_sat : left_base;
        right_next = (pos_base == POS_RIGHT) ? energy_sat : right_base;
    end

    // Channel count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= CHAN_RESET;
        end
        else if (cfg_valid)
        begin
            chan_reg <= cfg_data;
        end
    end

    // Block statistics; they are also the statistics fields of the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            peak_reg      <= '0;
            clip_reg      <= '0;
            nonzero_reg   <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
        end
        else
        begin
            if (word_ready)
            begin
                out_valid_reg <= word_valid;
            end
            if (take)
            begin
                pos_reg     <= pos_next;
                peak_reg    <= peak_next;
                clip_reg    <= clip_next;
                nonzero_reg <= nonzero_next;
                left_reg    <= left_next;
                right_reg   <= right_next;
            end
        end
    end

    // Per-sample result payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pcm_reg     <= word.pcm;
            clipped_reg <= word.clipped;
        end
    end

    assign out_valid      = out_valid_reg;
    assign low_byte       = pcm_reg[BYTE_W-1:0];
    assign high_byte      = pcm_reg[PCM_W-1:BYTE_W];
    assign clipped        = clipped_reg;
    assign peak_magnitude = peak_reg;
    assign clip_total     = clip_reg;
    assign nonzero_total  = nonzero_reg;
    assign left_energy    = left_reg;
    assign right_energy   = right_reg;

endmodule

FILE: rtl/core/pcm_saturate_and_stats.sv
// Top level of the PCM saturation and block statistics block.
// Depends on pcm_sat_pkg, the interfaces, pcm_sat_front and pcm_sat_stats.

// Takes one signed 32-bit sample per cycle when not stalled and returns its
// 16-bit saturated value as low and high bytes, a clip flag and the running
// block statistics that include this sample: peak input magnitude, clipped and
// nonzero counts (stopping at 2^24) and the left and right sums of squares
// (stopping at 2^54). Unstalled, the sustained rate is one word per cycle: the
// first register stage does the clamp and the 16x16 square, the second does
// the single statistics update whose result feeds the next word. A word with
// block_start set clears the statistics and channel position before it is
// counted. The channel count is written over the configuration channel, which
// is always ready; write it only while no word is in flight.
`include "pcm_saturate_and_stats_defines.svh"

module pcm_saturate_and_stats import pcm_sat_pkg::*; (
    input logic           clk,
    input logic           rst_n,
    pcm_sat_in_if.sink    samples,
    pcm_sat_out_if.source results,
    pcm_sat_cfg_if.sink   cfg
);

    logic          word_valid;
    logic          word_ready;
    pcm_sat_word_t word;

    // The channel count register takes a write in any cycle.
    assign cfg.ready = 1'b1;

    // Clamp and square stage.
    pcm_sat_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (samples.valid),
        .in_ready    (samples.ready),
        .sample      (samples.sample),
        .block_start (samples.block_start),
        .word_valid  (word_valid),
        .word_ready  (word_ready),
        .word        (word)
    );

    // Statistics and result stage.
    pcm_sat_stats u_stats (
        .clk            (clk),
        .rst_n          (rst_n),
        .word_valid     (word_valid),
        .word_ready     (word_ready),
        .word           (word),
        .cfg_valid      (cfg.valid && cfg.ready),
        .cfg_data       (cfg.data),
        .out_valid      (results.valid),
        .out_ready      (results.ready),
        .low_byte       (results.low_byte),
        .high_byte      (results.high_byte),
        .clipped        (results.clipped),
        .peak_magnitude (results.peak_magnitude),
        .clip_total     (results.clip_total),
        .nonzero_total  (results.nonzero_total),
        .left_energy    (results.left_energy),
        .right_energy   (results.right_energy)
    );

    // A clipped sample always carries one of the two limit codes.
    `PCM_ASSERT_SAME(a_clip_code, clk, rst_n, results.valid && results.clipped,
        ({results.high_byte, results.low_byte} == PCM_POS_LIMIT) ||
        ({results.high_byte, results.low_byte} == PCM_NEG_LIMIT),
        "clipped result without a limit code")

    // Every clipped sample is nonzero, so the clip count never leads.
    `PCM_ASSERT_SAME(a_clip_le_nonzero, clk, rst_n, results.valid,
        results.clip_total <= results.nonzero_total,
        "clip count above nonzero count")

    // A word stalled in the first stage stays put until the result frees up.
    `PCM_ASSERT_NEXT(a_word_hold, clk, rst_n, word_valid && !word_ready,
        word_valid && $stable(word),
        "stalled word lost or changed")

endmodule
